@@ sv/sliding_window_arq_sender_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef SLIDING_WINDOW_ARQ_SENDER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_ARQ_SENDER_UNIT_ASSERT_SVH

// clocked property, held off while reset is asserted
`define SWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property that also holds during reset
`define SWA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// Types and codes shared by the sliding-window arq sender modules.
// ----------------------------------------------------------------------------
package swa_pkg;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_REFUSE   = 3'd1,
    CMD_TRANSMIT = 3'd2,
    CMD_START    = 3'd3,
    CMD_STOP     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TIMER = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_GBN = 2'd0,
    MODE_SR  = 2'd1,
    MODE_TCP = 2'd2
  } mode_e;

  localparam logic [1:0] REG_SEQ_SIZE = 2'd0;
  localparam logic [1:0] REG_WINDOW   = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  localparam logic [4:0] SEQ_SIZE_RST = 5'd10;
  localparam logic [3:0] WINDOW_RST   = 4'd5;
  localparam logic [1:0] MODE_RST     = 2'd0;

  // where the sequence number of an emitted word comes from
  typedef enum logic [2:0] {
    SRC_ZERO = 3'd0,
    SRC_NEXT = 3'd1,
    SRC_BASE = 3'd2,
    SRC_ACK  = 3'd3,
    SRC_TMR  = 3'd4,
    SRC_PTR  = 3'd5
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK,
    ST_SEND_TX,
    ST_START_BASE,
    ST_TMO_START,
    ST_REPLAY,
    ST_TMR_TX
  } state_e;

  typedef enum logic [0:0] {
    TMR_STAGE_TX,
    TMR_STAGE_START
  } tmr_stage_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic emit;
    cmd_e cmd;
    src_e src;
    logic last;
    logic next_inc;
    logic mark_clr_next;
    logic mark_set_ack;
    logic base_load_ack;
    logic walk_step;
    logic dup_inc;
    logic dup_clr;
    logic ptr_load;
    logic ptr_inc;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    op_e   op;
    mode_e mode;
    logic  ok;
    logic  full;
    logic  empty;
    logic  ack_valid;
    logic  tmr_valid;
    logic  dup_hit;
    logic  walk_more;
    logic  ack1_is_next;
    logic  ptr_last;
  } stat_t;

endpackage

@@ sv/swa_ctrl.sv @@
// ----------------------------------------------------------------------------
// swa_ctrl
// Sequencer: decodes each item and steps through the words it produces.
// ----------------------------------------------------------------------------
module swa_ctrl
  import swa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o
);

  state_e     state_q, state_d;
  tmr_stage_e stage_q, stage_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= TMR_STAGE_TX;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    ctrl_o  = '0;
    ctrl_o.cmd = CMD_NONE;
    ctrl_o.src = SRC_ZERO;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.latch = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.last = 1'b1;
        state_d = ST_IDLE;
        case (stat_i.op)
          OP_SEND: begin
            ctrl_o.src = SRC_NEXT;
            if (stat_i.full) begin
              ctrl_o.cmd = CMD_REFUSE;
            end else if (stat_i.mode == MODE_SR || stat_i.empty) begin
              ctrl_o.cmd = CMD_START;
              ctrl_o.last = 1'b0;
              ctrl_o.mark_clr_next = (stat_i.mode == MODE_SR);
              state_d = ST_SEND_TX;
            end else begin
              ctrl_o.cmd = CMD_TRANSMIT;
              ctrl_o.next_inc = 1'b1;
            end
          end
          OP_ACK: begin
            if (stat_i.ok && stat_i.mode == MODE_SR) begin
              if (stat_i.ack_valid) begin
                // mark now, report after the base has slid
                ctrl_o.emit = 1'b0;
                ctrl_o.mark_set_ack = 1'b1;
                state_d = ST_WALK;
              end
            end else if (stat_i.ok && stat_i.ack_valid) begin
              ctrl_o.cmd = CMD_STOP;
              ctrl_o.src = SRC_BASE;
              ctrl_o.base_load_ack = 1'b1;
              ctrl_o.dup_clr = (stat_i.mode == MODE_TCP);
              ctrl_o.last = stat_i.ack1_is_next;
              if (!stat_i.ack1_is_next) begin
                state_d = ST_START_BASE;
              end
            end else if (stat_i.ok && stat_i.mode == MODE_TCP && !stat_i.empty) begin
              ctrl_o.dup_inc = 1'b1;
              if (stat_i.dup_hit) begin
                // fast retransmit of the oldest word
                ctrl_o.cmd = CMD_TRANSMIT;
                ctrl_o.src = SRC_BASE;
                ctrl_o.last = 1'b0;
                state_d = ST_START_BASE;
              end
            end
          end
          OP_TIMER: begin
            if (stat_i.mode == MODE_GBN) begin
              if (!stat_i.empty) begin
                ctrl_o.cmd = CMD_STOP;
                ctrl_o.src = SRC_TMR;
                ctrl_o.last = 1'b0;
                ctrl_o.ptr_load = 1'b1;
                state_d = ST_TMO_START;
              end
            end else if (stat_i.tmr_valid) begin
              ctrl_o.cmd = CMD_STOP;
              ctrl_o.src = SRC_TMR;
              ctrl_o.last = 1'b0;
              stage_d = TMR_STAGE_TX;
              state_d = ST_TMR_TX;
            end
          end
          default: begin
          end
        endcase
      end
      ST_WALK: begin
        if (stat_i.walk_more) begin
          ctrl_o.walk_step = 1'b1;
        end else begin
          ctrl_o.emit = 1'b1;
          ctrl_o.cmd  = CMD_STOP;
          ctrl_o.src  = SRC_ACK;
          ctrl_o.last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SEND_TX: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.cmd  = CMD_TRANSMIT;
        ctrl_o.src  = SRC_NEXT;
        ctrl_o.last = 1'b1;
        ctrl_o.next_inc = 1'b1;
        state_d = ST_IDLE;
      end
      ST_START_BASE: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.cmd  = CMD_START;
        ctrl_o.src  = SRC_BASE;
        ctrl_o.last = 1'b1;
        state_d = ST_IDLE;
      end
      ST_TMO_START: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.cmd  = CMD_START;
        ctrl_o.src  = SRC_BASE;
        state_d = ST_REPLAY;
      end
      ST_REPLAY: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.cmd  = CMD_TRANSMIT;
        ctrl_o.src  = SRC_PTR;
        ctrl_o.last = stat_i.ptr_last;
        ctrl_o.ptr_inc = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_TMR_TX: begin
        ctrl_o.emit = 1'b1;
        ctrl_o.src  = SRC_TMR;
        if (stage_q == TMR_STAGE_TX) begin
          ctrl_o.cmd = CMD_TRANSMIT;
          stage_d = TMR_STAGE_START;
        end else begin
          ctrl_o.cmd  = CMD_START;
          ctrl_o.last = 1'b1;
          stage_d = TMR_STAGE_TX;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/swa_datapath.sv @@
// ----------------------------------------------------------------------------
// swa_datapath
// Window registers, ack marks, configuration and the result register.
// ----------------------------------------------------------------------------
module swa_datapath
  import swa_pkg::*;
#(
  parameter int SEQ_MAX = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  output stat_t      stat_o,
  input  logic [1:0] operation_i,
  input  logic [3:0] ack_number_i,
  input  logic       checksum_ok_i,
  input  logic [3:0] timer_seq_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [2:0] command_o,
  output logic [3:0] seq_number_o,
  output logic       last_o
);

  // the 5-bit size register caps the usable space at 31
  localparam int SMax = (SEQ_MAX < 31) ? SEQ_MAX : 31;
  localparam int SeqW = $clog2(SMax);
  localparam int CntW = $clog2(SMax + 1);
  localparam int EW   = ((CntW > 4) ? CntW : 4) + 1;

  logic [4:0]      seq_size_q;
  logic [3:0]      window_q;
  logic [1:0]      mode_q;
  logic [SeqW-1:0] base_q, next_q, ptr_q;
  logic [1:0]      dup_q;
  logic [SMax-1:0] marks_q;
  logic [1:0]      op_q;
  logic [3:0]      ack_q, tmr_q;
  logic            ok_q;
  logic            res_valid_q;
  logic [2:0]      res_cmd_q;
  logic [3:0]      res_seq_q;
  logic            res_last_q;

  logic [CntW-1:0] s_eff;
  logic [EW-1:0]   sx, wx, bx, nx, ax, tx, px, smin1, wraw;
  logic [EW-1:0]   outst, dist_a, dist_t, ack1, ptr1, base1, next1;
  logic            cfg_hit;
  logic [3:0]      seq_sel;

  function automatic logic [EW-1:0] seq_dist(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                             input logic [EW-1:0] s);
    seq_dist = (a >= b) ? (a - b) : (a + s - b);
  endfunction

  function automatic logic [EW-1:0] incr(input logic [EW-1:0] a, input logic [EW-1:0] s);
    incr = ((a + EW'(1)) == s) ? '0 : (a + EW'(1));
  endfunction

  // effective sizes
  always_comb begin
    if (seq_size_q < 5'd2) begin
      s_eff = CntW'(2);
    end else if (seq_size_q > 5'(SMax)) begin
      s_eff = CntW'(SMax);
    end else begin
      s_eff = seq_size_q[CntW-1:0];
    end
  end

  assign sx    = EW'(s_eff);
  assign smin1 = sx - EW'(1);
  assign wraw  = EW'(window_q);
  assign wx    = (wraw == '0) ? EW'(1) : ((wraw > smin1) ? smin1 : wraw);
  assign bx    = EW'(base_q);
  assign nx    = EW'(next_q);
  assign px    = EW'(ptr_q);
  assign ax    = EW'(ack_q);
  assign tx    = EW'(tmr_q);

  assign outst  = seq_dist(nx, bx, sx);
  assign dist_a = seq_dist(ax, bx, sx);
  assign dist_t = seq_dist(tx, bx, sx);
  assign ack1   = incr(ax, sx);
  assign ptr1   = incr(px, sx);
  assign base1  = incr(bx, sx);
  assign next1  = incr(nx, sx);

  always_comb begin
    stat_o.op           = op_e'(op_q);
    stat_o.mode         = (mode_q == 2'd3) ? MODE_GBN : mode_e'(mode_q);
    stat_o.ok           = ok_q;
    stat_o.full         = (outst >= wx);
    stat_o.empty        = (outst == '0);
    stat_o.ack_valid    = (ax < sx) && (dist_a < outst);
    stat_o.tmr_valid    = (tx < sx) && (dist_t < outst);
    stat_o.dup_hit      = (dup_q >= 2'd2);
    stat_o.walk_more    = (base_q != next_q) && marks_q[base_q];
    stat_o.ack1_is_next = (ack1 == nx);
    stat_o.ptr_last     = (ptr1 == nx);
  end

  // configuration, always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i && (cfg_index_i == REG_SEQ_SIZE ||
                                   cfg_index_i == REG_WINDOW || cfg_index_i == REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_size_q <= SEQ_SIZE_RST;
      window_q   <= WINDOW_RST;
      mode_q     <= MODE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SEQ_SIZE: seq_size_q <= cfg_data_i;
        REG_WINDOW:   window_q   <= cfg_data_i[3:0];
        REG_MODE:     mode_q     <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      next_q  <= '0;
      ptr_q   <= '0;
      dup_q   <= '0;
      marks_q <= '0;
    end else if (cfg_hit) begin
      base_q  <= '0;
      next_q  <= '0;
      dup_q   <= '0;
      marks_q <= '0;
    end else begin
      if (ctrl_i.next_inc) begin
        next_q <= next1[SeqW-1:0];
      end
      if (ctrl_i.mark_clr_next) begin
        marks_q[next_q] <= 1'b0;
      end
      if (ctrl_i.mark_set_ack) begin
        marks_q[ack_q[SeqW-1:0]] <= 1'b1;
      end
      if (ctrl_i.base_load_ack) begin
        base_q <= ack1[SeqW-1:0];
      end
      if (ctrl_i.walk_step) begin
        marks_q[base_q] <= 1'b0;
        base_q <= base1[SeqW-1:0];
      end
      if (ctrl_i.dup_clr) begin
        dup_q <= '0;
      end else if (ctrl_i.dup_inc && dup_q != 2'd3) begin
        dup_q <= dup_q + 2'd1;
      end
      if (ctrl_i.ptr_load) begin
        ptr_q <= base_q;
      end else if (ctrl_i.ptr_inc) begin
        ptr_q <= ptr1[SeqW-1:0];
      end
    end
  end

  // item fields held for the length of the item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      op_q  <= operation_i;
      ack_q <= ack_number_i;
      ok_q  <= checksum_ok_i;
      tmr_q <= timer_seq_i;
    end
  end

  always_comb begin
    case (ctrl_i.src)
      SRC_NEXT: seq_sel = nx[3:0];
      SRC_BASE: seq_sel = bx[3:0];
      SRC_ACK:  seq_sel = ack_q;
      SRC_TMR:  seq_sel = tmr_q;
      SRC_PTR:  seq_sel = px[3:0];
      default:  seq_sel = 4'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ctrl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      res_cmd_q  <= ctrl_i.cmd;
      res_seq_q  <= seq_sel;
      res_last_q <= ctrl_i.last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign command_o      = res_cmd_q;
  assign seq_number_o   = res_seq_q;
  assign last_o         = res_last_q;

endmodule

@@ sv/sliding_window_arq_sender_unit.sv @@
// ----------------------------------------------------------------------------
// sliding_window_arq_sender_unit
// Sliding-window arq sender: go-back-n, selective repeat, tcp-like modes.
// ----------------------------------------------------------------------------
// the edge that takes start latches the item; the decode state then registers the first word
// (a selective-repeat ack waits out its base walk), then one word per cycle.
// busy falls as the last word shows; a selective-repeat ack first slides its base
// over each marked slot before it reports.
// results cannot be stalled; reset clears the window, marks and duplicate count and
// loads seq_size 10, window_size 5, go-back-n; any register write clears the window.
module sliding_window_arq_sender_unit
  import swa_pkg::*;
#(
  parameter int SEQ_MAX = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] operation_i,
  input  logic [3:0] ack_number_i,
  input  logic       checksum_ok_i,
  input  logic [3:0] timer_seq_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [2:0] command_o,
  output logic [3:0] seq_number_o,
  output logic       last_o
);

  ctrl_t ctrl;
  stat_t stat;

  swa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  swa_datapath #(
    .SEQ_MAX(SEQ_MAX)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .operation_i   (operation_i),
    .ack_number_i  (ack_number_i),
    .checksum_ok_i (checksum_ok_i),
    .timer_seq_i   (timer_seq_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .command_o     (command_o),
    .seq_number_o  (seq_number_o),
    .last_o        (last_o)
  );

endmodule

@@ sv/swa_checker.sv @@
// ----------------------------------------------------------------------------
// swa_checker
// Port-level checks on the sender's command and result timing.
// ----------------------------------------------------------------------------
`include "sliding_window_arq_sender_unit_assert.svh"

module swa_checker
  import swa_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_i,
  input logic       result_valid_i,
  input logic [2:0] command_i,
  input logic       last_i
);

  // a taken item raises busy
  `SWA_ASSERT(a_start_busy, start_i && !busy_i |=> busy_i, "accepted item did not raise busy")

  // words before the last one come while busy, the last one ends it
  `SWA_ASSERT(a_mid_busy, result_valid_i && !last_i |-> busy_i, "non-final word while idle")
  `SWA_ASSERT(a_last_idle, result_valid_i && last_i |-> !busy_i, "busy after final word")

  `SWA_ASSERT(a_cmd_code, result_valid_i |-> command_i <= CMD_STOP, "undefined command word")

  `SWA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !result_valid_i && !busy_i, "reset activity")

endmodule

bind sliding_window_arq_sender_unit swa_checker u_swa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_i        (busy_o),
  .result_valid_i(result_valid_o),
  .command_i     (command_o),
  .last_i        (last_o)
);
